[src/ipv6_address_text_formatter_assert.svh]
// assertion helpers for the address text formatter
`ifndef IPV6_ADDRESS_TEXT_FORMATTER_ASSERT_SVH
`define IPV6_ADDRESS_TEXT_FORMATTER_ASSERT_SVH

// same-cycle implication, idle during reset
`define IPV6FMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define IPV6FMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ipv6fmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ipv6fmt_pkg;

    localparam int unsigned AddrW  = 128;
    localparam int unsigned NumGrp = 8;
    localparam int unsigned QDepth = 2;

    localparam logic [7:0] ChColon = 8'h3a;
    localparam logic [7:0] ChDot   = 8'h2e;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChHexA  = 8'h57; // 'a' minus ten

    // one classified address on its way from front to back
    typedef struct packed {
        logic [AddrW-1:0] addr;      // byte 0 in the top bits
        logic             v4;        // dotted decimal form
        logic [3:0]       run_start; // 8 when no run is compressed
        logic [3:0]       run_len;
    } t_item;

    function automatic logic [15:0] get_group(input logic [AddrW-1:0] a, input logic [2:0] g);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < NumGrp; k++) begin
            if (g == 3'(k)) begin
                r = a[(NumGrp-1-k)*16 +: 16];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] get_v4_byte(input logic [31:0] w, input logic [1:0] b);
        logic [7:0] r;
        unique case (b)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

    // position of the most significant nonzero nibble, 0 for a zero group
    function automatic logic [1:0] lead_nib(input logic [15:0] g);
        logic [1:0] r;
        if (g[15:12] != 4'd0) r = 2'd3;
        else if (g[11:8] != 4'd0) r = 2'd2;
        else if (g[7:4] != 4'd0) r = 2'd1;
        else r = 2'd0;
        return r;
    endfunction

    function automatic logic [1:0] lead_dec(input logic [7:0] b);
        logic [1:0] r;
        if (b >= 8'd100) r = 2'd2;
        else if (b >= 8'd10) r = 2'd1;
        else r = 2'd0;
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) r = ChZero + {4'd0, n};
        else r = ChHexA + {4'd0, n};
        return r;
    endfunction

    // decimal digit of a byte: d = 2 hundreds, 1 tens, 0 units
    function automatic logic [3:0] dec_digit(input logic [7:0] b, input logic [1:0] d);
        logic [1:0] h;
        logic [7:0] rem;
        logic [3:0] t;
        logic [7:0] u;
        logic [3:0] r;
        if (b >= 8'd200) h = 2'd2;
        else if (b >= 8'd100) h = 2'd1;
        else h = 2'd0;
        rem = b - 8'(h * 100);
        t = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 8'(k * 10)) t = 4'(k);
        end
        u = rem - 8'(t * 10);
        unique case (d)
            2'd2: r = {2'd0, h};
            2'd1: r = t;
            default: r = u[3:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ipv6fmt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv6fmt_front (
    input  wire logic                     i_valid,
    input  wire logic [127:0]             i_data,
    input  wire logic                     i_q_full,
    output logic                          o_ready,
    output logic                          o_push,
    output ipv6fmt_pkg::t_item            o_item
);
    import ipv6fmt_pkg::*;

    logic [63:0] hi, lo;
    logic        first12, mapped, zero_addr;
    logic [NumGrp-1:0] zg;
    logic [3:0] cur_len, cur_start, best_len, best_start;

    assign hi = i_data[63:0];
    assign lo = i_data[127:64];

    assign first12   = (hi == 64'd0) && (lo[63:32] == 32'd0);
    assign mapped    = (hi == 64'd0) && (lo[63:32] == 32'h0000_ffff);
    assign zero_addr = first12 && (lo[31:0] == 32'd0);

    always_comb begin
        for (int k = 0; k < NumGrp; k++) begin
            zg[k] = (get_group({hi, lo}, 3'(k)) == 16'd0);
        end
    end

    // first longest run of at least two zero groups
    always_comb begin
        cur_len    = 4'd0;
        cur_start  = 4'd0;
        best_len   = 4'd0;
        best_start = 4'(NumGrp);
        for (int k = 0; k < NumGrp; k++) begin
            if (zg[k]) begin
                if (cur_len == 4'd0) cur_start = 4'(k);
                cur_len = cur_len + 4'd1;
                if (cur_len > best_len && cur_len >= 4'd2) begin
                    best_len   = cur_len;
                    best_start = cur_start;
                end
            end else begin
                cur_len = 4'd0;
            end
        end
    end

    assign o_ready          = !i_q_full;
    assign o_push           = i_valid && !i_q_full;
    assign o_item.addr      = {hi, lo};
    assign o_item.v4        = mapped || (first12 && !zero_addr);
    assign o_item.run_start = best_start;
    assign o_item.run_len   = best_len;

endmodule

`default_nettype wire

[src/ipv6fmt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv6fmt_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire ipv6fmt_pkg::t_item       i_item,
    input  wire logic                     i_pop,
    output logic                          o_full,
    output logic                          o_valid,
    output ipv6fmt_pkg::t_item            o_item
);
    import ipv6fmt_pkg::*;

    t_item      r_mem [QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            if (i_push && !i_pop) r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    assign o_full  = (r_cnt == 2'(QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

endmodule

`default_nettype wire

[src/ipv6fmt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ipv6fmt_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire ipv6fmt_pkg::t_item       i_q_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [7:0]                    o_char,
    output logic                          o_last
);
    import ipv6fmt_pkg::*;

    typedef enum logic [2:0] {
        PH_DC1, PH_DC2, PH_SEP, PH_HEX, PH_DOT, PH_DEC
    } t_phase;

    // current item
    logic [127:0] r_addr;
    logic [3:0]   r_bs, r_bl;
    logic         r_busy, n_busy;
    t_phase       r_ph, n_ph;
    logic [2:0]   r_idx, n_idx;
    logic [1:0]   r_dig, n_dig;
    // output word
    logic         r_ovalid, n_ovalid;
    logic [7:0]   r_ochar, n_ochar;
    logic         r_olast, n_olast;

    logic         adv, ld;
    logic [7:0]   cur_char;
    logic         cur_last;
    t_phase       st_ph;
    logic [2:0]   st_idx;
    logic [1:0]   st_dig;
    logic [15:0]  grp_cur;
    logic [3:0]   nib;
    logic [7:0]   byte_cur;
    logic [3:0]   run_end;
    logic [3:0]   idx_inc;
    t_phase       ld_ph;
    logic [1:0]   ld_dig;

    assign grp_cur  = get_group(r_addr, r_idx);
    assign nib      = grp_cur[{r_dig, 2'b00} +: 4];
    assign byte_cur = get_v4_byte(r_addr[31:0], r_idx[1:0]);
    assign run_end  = r_bs + r_bl;
    assign idx_inc  = {1'b0, r_idx} + 4'd1;

    // emit the character of the current phase and find the step after it
    always_comb begin
        cur_char = ChColon;
        cur_last = 1'b0;
        st_ph    = r_ph;
        st_idx   = r_idx;
        st_dig   = r_dig;
        unique case (r_ph)
            PH_DC1: begin
                st_ph = PH_DC2;
            end
            PH_DC2: begin
                cur_last = (run_end == 4'(NumGrp));
                st_idx   = run_end[2:0];
                st_ph    = PH_HEX;
                st_dig   = lead_nib(get_group(r_addr, run_end[2:0]));
            end
            PH_SEP: begin
                st_ph  = PH_HEX;
                st_dig = lead_nib(grp_cur);
            end
            PH_HEX: begin
                cur_char = hex_char(nib);
                cur_last = (r_dig == 2'd0) && (r_idx == 3'(NumGrp - 1));
                if (r_dig != 2'd0) begin
                    st_dig = r_dig - 2'd1;
                end else begin
                    st_idx = idx_inc[2:0];
                    st_ph  = (idx_inc == r_bs) ? PH_DC1 : PH_SEP;
                end
            end
            PH_DOT: begin
                cur_char = ChDot;
                st_ph    = PH_DEC;
                st_dig   = lead_dec(byte_cur);
            end
            PH_DEC: begin
                cur_char = ChZero + {4'd0, dec_digit(byte_cur, r_dig)};
                cur_last = (r_dig == 2'd0) && (r_idx == 3'd3);
                if (r_dig != 2'd0) begin
                    st_dig = r_dig - 2'd1;
                end else begin
                    st_idx = idx_inc[2:0];
                    st_ph  = PH_DOT;
                end
            end
            default: begin
                cur_last = 1'b1;
            end
        endcase
    end

    // entry phase of the item at the queue head
    always_comb begin
        if (i_q_item.v4) begin
            ld_ph  = PH_DEC;
            ld_dig = lead_dec(i_q_item.addr[31:24]);
        end else if (i_q_item.run_start == 4'd0) begin
            ld_ph  = PH_DC1;
            ld_dig = 2'd0;
        end else begin
            ld_ph  = PH_HEX;
            ld_dig = lead_nib(i_q_item.addr[127:112]);
        end
    end

    assign adv   = r_busy && (!r_ovalid || i_ready);
    assign ld    = i_q_valid && (!r_busy || (adv && cur_last));
    assign o_pop = ld;

    always_comb begin
        n_busy   = r_busy;
        n_ph     = r_ph;
        n_idx    = r_idx;
        n_dig    = r_dig;
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        if (adv) begin
            n_ovalid = 1'b1;
            n_ochar  = cur_char;
            n_olast  = cur_last;
            n_ph     = st_ph;
            n_idx    = st_idx;
            n_dig    = st_dig;
            if (cur_last) n_busy = 1'b0;
        end else if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (ld) begin
            n_busy = 1'b1;
            n_ph   = ld_ph;
            n_idx  = 3'd0;
            n_dig  = ld_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_addr <= i_q_item.addr;
            r_bs   <= i_q_item.run_start;
            r_bl   <= i_q_item.run_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ph     <= PH_DC1;
            r_idx    <= 3'd0;
            r_dig    <= 2'd0;
            r_ovalid <= 1'b0;
            r_ochar  <= 8'd0;
            r_olast  <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_ph     <= n_ph;
            r_idx    <= n_idx;
            r_dig    <= n_dig;
            r_ovalid <= n_ovalid;
            r_ochar  <= n_ochar;
            r_olast  <= n_olast;
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

[src/ipv6_address_text_formatter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ipv6 address to text, one ascii character per output word
// input stream: one 128-bit address per word, {addr_low, addr_high} in tdata
// output stream: one character per word in tdata, tlast on the final one
// text is dotted decimal for ipv4-mapped and ipv4-compatible addresses,
// otherwise lowercase hex, the first longest run of two or more zero groups as "::"
// an address gives 2 to 39 characters, one per cycle while the sink is ready
// back to back addresses stream with no gap between their texts
// an accepted address is queued and loaded into the sequencer before its first character shows
// a classifier finds the form and the zero run as the address arrives and
// writes it into a two-entry queue; the sequencer drains the queue
// input ready drops only when the queue is full
// when the sink stalls, the output word holds and the sequencer waits
// reset empties the queue and drops the output valid

module ipv6_address_text_formatter (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // addr_high [63:0], addr_low [127:64]
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,  // text_char [7:0]
    output logic              o_m_axis_tlast   // last_char
);
    import ipv6fmt_pkg::*;

    logic  push, pop, q_full, q_valid;
    t_item fr_item, q_item;

    // classify the word and queue it
    ipv6fmt_front u_front (
        .i_valid  (i_s_axis_tvalid),
        .i_data   (i_s_axis_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_item   (fr_item)
    );

    ipv6fmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // character sequencer with registered output word
    ipv6fmt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_char    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[src/ipv6fmt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "ipv6_address_text_formatter_assert.svh"

module ipv6fmt_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [7:0]   o_m_axis_tdata,
    input wire logic         o_m_axis_tlast
);
    logic       is_digit, is_hex_letter, is_colon, is_dot, char_ok;
    logic       vld, stall, last_vld;
    logic [8:0] word;

    assign is_digit      = (o_m_axis_tdata >= 8'h30) && (o_m_axis_tdata <= 8'h39);
    assign is_hex_letter = (o_m_axis_tdata >= 8'h61) && (o_m_axis_tdata <= 8'h66);
    assign is_colon      = (o_m_axis_tdata == 8'h3a);
    assign is_dot        = (o_m_axis_tdata == 8'h2e);
    assign char_ok       = is_digit || is_hex_letter || is_colon || is_dot;
    assign vld           = o_m_axis_tvalid;
    assign stall         = o_m_axis_tvalid && !i_m_axis_tready;
    assign last_vld      = o_m_axis_tvalid && o_m_axis_tlast;
    assign word          = {o_m_axis_tlast, o_m_axis_tdata};

    // a stalled output word holds
    `IPV6FMT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, vld && $stable(word), "word changed")
    // only address text characters come out
    `IPV6FMT_ASSERT_NOW(a_charset, i_clk, i_rst_n, vld, char_ok, "bad character")
    // text never ends on a dot
    `IPV6FMT_ASSERT_NOW(a_last_not_dot, i_clk, i_rst_n, last_vld, !is_dot, "text ends in a dot")
    // a full queue means the sequencer is busy and has a word out
    `IPV6FMT_ASSERT_NOW(a_full_vld, i_clk, i_rst_n, !o_s_axis_tready, vld, "idle yet full")

endmodule

bind ipv6_address_text_formatter ipv6fmt_checker u_ipv6fmt_checker (.*);

`default_nettype wire

[sim/ipv6_address_text_formatter_tb.sv]
`timescale 1ns / 1ps

module ipv6_address_text_formatter_tb;

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;

    // extra wait once every expected character has come out
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned RAND_PER_PHASE = 124;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned addr_no;
    } text_char_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic [127:0] i_s_axis_tdata = '0;   // addr_high [63:0], addr_low [127:64]
    logic         i_m_axis_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [7:0]   o_m_axis_tdata;        // text_char [7:0]
    logic         o_m_axis_tlast;        // last_char

    text_char_t   expected_text[$];
    int unsigned  addr_count = 0;
    int unsigned  chars_checked = 0;
    int unsigned  dotted_count = 0;
    int unsigned  compressed_count = 0;
    int unsigned  error_count = 0;
    int unsigned  src_idle_pct = 0;
    int unsigned  snk_idle_pct = 0;

    ipv6_address_text_formatter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // expected text of one address, queued one character per word
    function automatic void predict_text(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] a;
        logic [7:0]   txt[$];
        logic [15:0]  grp[8];
        logic [7:0]   oct;
        logic [3:0]   nib;
        int           run_at;
        int           run_len;
        int           g;
        int           j;
        int           k;
        bit           started;
        text_char_t   tc;
        a = {hi, lo};
        if (hi == '0 && (lo[63:32] == 32'h0000_ffff ||
                         (lo[63:32] == '0 && lo[31:0] != '0))) begin
            // mapped or compatible: dotted decimal of the last four bytes
            dotted_count++;
            for (k = 0; k < 4; k++) begin
                oct = lo[31 - 8*k -: 8];
                if (k != 0) txt.push_back(CH_DOT);
                if (oct >= 100) txt.push_back(8'(CH_ZERO + oct / 100));
                if (oct >= 10) txt.push_back(8'(CH_ZERO + (oct / 10) % 10));
                txt.push_back(8'(CH_ZERO + oct % 10));
            end
        end else begin
            for (g = 0; g < 8; g++) grp[g] = a[127 - 16*g -: 16];
            // first longest run of at least two zero groups
            run_at = 8;
            run_len = 0;
            g = 0;
            while (g < 8) begin
                if (grp[g] != '0) begin
                    g++;
                end else begin
                    j = g;
                    while (j < 8 && grp[j] == '0) j++;
                    if (j - g > run_len && j - g >= 2) begin
                        run_at = g;
                        run_len = j - g;
                    end
                    g = j;
                end
            end
            if (run_len != 0) compressed_count++;
            g = 0;
            while (g < 8) begin
                if (g == run_at) begin
                    txt.push_back(CH_COLON);
                    txt.push_back(CH_COLON);
                    g += run_len;
                end else begin
                    if (g != 0 && g != run_at + run_len) txt.push_back(CH_COLON);
                    started = 1'b0;
                    for (k = 3; k >= 0; k--) begin
                        nib = grp[g][4*k +: 4];
                        if (nib != '0 || started || k == 0) begin
                            started = 1'b1;
                            txt.push_back(nib < 10 ? 8'(CH_ZERO + nib) : 8'(CH_A + nib - 10));
                        end
                    end
                    g++;
                end
            end
        end
        for (k = 0; k < txt.size(); k++) begin
            tc.ch = txt[k];
            tc.last = (k == txt.size() - 1);
            tc.addr_no = addr_count;
            expected_text.push_back(tc);
        end
    endfunction

    // one address word; valid stays high when the next word follows at once
    task automatic send_addr(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_text(hi, lo);
        addr_count++;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {lo, hi};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // hold the sender until every queued character has come out
    task automatic wait_text_done();
        i_s_axis_tvalid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_group();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'h0000;
            4, 5, 6: return 16'($urandom);
            default: return 16'($urandom) >> (4 * $urandom_range(1, 3));
        endcase
    endfunction

    // mostly group-structured addresses so zero runs of every length show up
    function automatic void rand_addr(output logic [63:0] hi, output logic [63:0] lo);
        case ($urandom_range(0, 9))
            0: begin
                hi = '0;
                lo = {32'h0000_ffff, 32'($urandom)};
            end
            1: begin
                hi = '0;
                lo = {32'h0, 32'($urandom)};
            end
            2: begin
                hi = {32'($urandom), 32'($urandom)};
                lo = {32'($urandom), 32'($urandom)};
            end
            default: begin
                hi = {rand_group(), rand_group(), rand_group(), rand_group()};
                lo = {rand_group(), rand_group(), rand_group(), rand_group()};
            end
        endcase
    endfunction

    task automatic test_special_forms();
        send_addr(64'h0, 64'h0);                                    // all zero
        send_addr('1, '1);                                          // longest text
        send_addr(64'h0, 64'h1);                                    // ::1 as dotted
        send_addr(64'h0, 64'h0000_ffff_0000_0000);                  // mapped zero
        send_addr(64'h0, 64'h0000_ffff_ffff_ffff);                  // mapped max
        send_addr(64'h0, 64'h0000_0000_c0a8_000a);                  // compatible
        send_addr(64'h0, 64'h0000_0001_0000_0000);                  // not compatible
        send_addr(64'h0, 64'h0000_fffe_0102_0304);                  // near mapped
        send_addr(64'h0, 64'h0001_ffff_0a00_0001);                  // near mapped
        send_addr(64'h0000_0000_0000_0001, '1);                     // run at start
        wait_text_done();
    endtask

    task automatic test_zero_runs();
        send_addr(64'h0001_0000_0000_0000, 64'h0);                  // run at end
        send_addr(64'h8000_0000_0000_0000, 64'h0);
        send_addr(64'h0001_0000_0000_0000, 64'h1);                  // run in middle
        send_addr(64'h0001_0000_0000_0001, 64'h0000_0000_0001_0001); // equal runs
        send_addr(64'h0001_0000_0001_0000, 64'h0000_0000_0001_0001); // longer later
        send_addr(64'h0001_0000_0001_0001, 64'h0001_0001_0001_0001); // single zero
        send_addr(64'h000f_00f0_0f00_f000, 64'h0abc_1234_00de_beef); // leading zeros
        send_addr(64'h0, 64'h0001_0000_0000_0000);                  // two runs
        send_addr(64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001);
        send_addr(64'hfe80_0000_0000_0000, 64'h0202_b3ff_fe1e_8329);
        wait_text_done();
    endtask

    task automatic test_random_phase(input int unsigned src_pct, input int unsigned snk_pct);
        logic [63:0] hi;
        logic [63:0] lo;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int n = 0; n < RAND_PER_PHASE; n++) begin
            rand_addr(hi, lo);
            send_addr(hi, lo);
            if (n == RAND_PER_PHASE / 2) wait_text_done();
        end
        wait_text_done();
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // output checker: each character word against the oldest expectation
    always @(posedge i_clk) begin
        text_char_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_text.size() == 0) begin
                report_mismatch($sformatf("unexpected word char=%h last=%b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want = expected_text.pop_front();
                chars_checked++;
                if (o_m_axis_tdata !== want.ch)
                    report_mismatch($sformatf("addr %0d char got %h want %h",
                                              want.addr_no, o_m_axis_tdata, want.ch));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("addr %0d last got %b want %b",
                                              want.addr_no, o_m_axis_tlast, want.last));
            end
        end
    end

    initial begin
        src_idle_pct = 15;
        snk_idle_pct = 72;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_forms();
        test_zero_runs();
        test_random_phase(15, 72);
        test_random_phase(72, 15);
        test_random_phase(0, 0);
        if (expected_text.size() != 0)
            report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
        $display("covered %0d addresses (%0d dotted, %0d with a compressed zero run)",
                 addr_count, dotted_count, compressed_count);
        $display("checked %0d characters under three sender/receiver stall profiles",
                 chars_checked);
        if (error_count == 0) begin
            $display("ipv6_address_text_formatter_tb: PASS");
        end else begin
            $display("ipv6_address_text_formatter_tb: FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("ipv6_address_text_formatter_tb: FAIL");
        $finish;
    end

endmodule
